// ===== rtl/core/vtp_pkg.sv =====
package vtp_pkg;

   localparam logic [2:0] MODE_BARS    = 3'd0;
   localparam logic [2:0] MODE_RAMP_H  = 3'd1;
   localparam logic [2:0] MODE_RAMP_V  = 3'd2;
   localparam logic [2:0] MODE_CHECKER = 3'd3;
   localparam logic [2:0] MODE_GREEN   = 3'd4;
   localparam logic [2:0] MODE_BOX     = 3'd5;

   localparam logic [1:0] CSR_PATTERN_MODE = 2'd0;
   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd2;

   localparam logic [1:0] SLOT_X0  = 2'd0;
   localparam logic [1:0] SLOT_X1  = 2'd1;
   localparam logic [1:0] SLOT_ROW = 2'd2;

   localparam logic [1:0] CH_LUMA0 = 2'd0;
   localparam logic [1:0] CH_LUMA1 = 2'd1;
   localparam logic [1:0] CH_U     = 2'd2;
   localparam logic [1:0] CH_V     = 2'd3;

   localparam int CSR_W        = 11;
   localparam int MIN_WIDTH    = 8;
   localparam int CHECK_SIZE   = 20;
   localparam int RECIP_1000   = 268436;
   localparam int RECIP_SHIFT  = 28;

   localparam logic [15:0] COLOUR_GREEN = 16'h07E0;
   localparam logic [15:0] COLOUR_RED   = 16'hF800;
   localparam logic [15:0] COLOUR_FIELD = 16'h0010;
   localparam logic [15:0] COLOUR_WHITE = 16'hFFFF;
   localparam logic [15:0] COLOUR_BLACK = 16'h0000;

   typedef struct packed {
      logic       accept_pair;
      logic       accept_tick;
      logic       div_load;
      logic       div_step;
      logic       div_last;
      logic [1:0] slot;
      logic       pix;
      logic       sum;
      logic       mul;
      logic       fin;
      logic [1:0] ch;
      logic       out_load;
   } vtp_cmd_type;

   typedef struct packed {
      logic out_free;
   } vtp_sts_type;

   function automatic logic [15:0] bar_colour(input logic [2:0] idx);
      logic [15:0] c;
      unique case (idx)
         3'd0: c = 16'hFFFF;
         3'd1: c = 16'hFFE0;
         3'd2: c = 16'h07FF;
         3'd3: c = 16'h07E0;
         3'd4: c = 16'hF81F;
         3'd5: c = 16'hF800;
         3'd6: c = 16'h001F;
         default: c = 16'h0000;
      endcase
      return c;
   endfunction

   function automatic logic [15:0] grey565(input logic [7:0] i);
      return {i[7:3], i[7:2], i[7:3]};
   endfunction

endpackage

// ===== rtl/core/vtp_ctrl.sv =====
module vtp_ctrl
   import vtp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_func,
   input  vtp_sts_type sts,
   output logic        req_stall,
   output vtp_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DLOAD, ST_DSTEP, ST_PIX, ST_SUM, ST_MUL, ST_FIN, ST_DONE
   } state_type;

   state_type  state_ff;
   logic [1:0] slot_ff;
   logic [2:0] bit_ff;
   logic [1:0] ch_ff;
   logic       accept;

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd             = '0;
      cmd.slot        = slot_ff;
      cmd.ch          = ch_ff;
      cmd.accept_pair = accept && !req_func;
      cmd.accept_tick = accept && req_func;
      cmd.div_load    = (state_ff == ST_DLOAD);
      cmd.div_step    = (state_ff == ST_DSTEP);
      cmd.div_last    = (state_ff == ST_DSTEP) && (&bit_ff);
      cmd.pix         = (state_ff == ST_PIX);
      cmd.sum         = (state_ff == ST_SUM);
      cmd.mul         = (state_ff == ST_MUL);
      cmd.fin         = (state_ff == ST_FIN);
      cmd.out_load    = (state_ff == ST_DONE) && sts.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slot_ff  <= SLOT_X0;
         bit_ff   <= '0;
         ch_ff    <= CH_LUMA0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.accept_pair) begin
                  state_ff <= ST_DLOAD;
                  slot_ff  <= SLOT_X0;
               end
            end
            ST_DLOAD: begin
               bit_ff   <= '0;
               state_ff <= ST_DSTEP;
            end
            ST_DSTEP: begin
               bit_ff <= bit_ff + 3'd1;
               if (&bit_ff) begin
                  if (slot_ff == SLOT_ROW) begin
                     state_ff <= ST_PIX;
                  end else begin
                     slot_ff  <= slot_ff + 2'd1;
                     state_ff <= ST_DLOAD;
                  end
               end
            end
            ST_PIX: begin
               ch_ff    <= CH_LUMA0;
               state_ff <= ST_SUM;
            end
            ST_SUM: state_ff <= ST_MUL;
            ST_MUL: state_ff <= ST_FIN;
            ST_FIN: begin
               if (ch_ff == CH_V) begin
                  state_ff <= ST_DONE;
               end else begin
                  ch_ff    <= ch_ff + 2'd1;
                  state_ff <= ST_SUM;
               end
            end
            ST_DONE: begin
               if (sts.out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_pair_starts_div: assert property (@(posedge clock) disable iff (reset)
      cmd.accept_pair |=> (state_ff == ST_DLOAD) && (slot_ff == SLOT_X0))
      else $error("request did not start the first division");

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept_pair, cmd.accept_tick, cmd.div_load, cmd.div_step,
                cmd.pix, cmd.sum, cmd.mul, cmd.fin, cmd.out_load}))
      else $error("more than one datapath command at once");

endmodule

// ===== rtl/core/vtp_dp.sv =====
module vtp_dp
   import vtp_pkg::*;
#(
   parameter int MAX_WIDTH     = 1024,
   parameter int MAX_HEIGHT    = 1024,
   parameter int BOX_SIZE      = 40,
   parameter int BOUNCE_WIDTH  = 320,
   parameter int BOUNCE_HEIGHT = 240
)
(
   input  logic              clock,
   input  logic              reset,
   input  vtp_cmd_type       cmd,
   output vtp_sts_type       sts,
   input  logic [2:0]        pattern_mode,
   input  logic [CSR_W-1:0]  frame_width,
   input  logic [CSR_W-1:0]  frame_height,
   input  logic              tick_even,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output logic [7:0]        rsp_luma_first,
   output logic [7:0]        rsp_chroma_blue,
   output logic [7:0]        rsp_luma_second,
   output logic [7:0]        rsp_chroma_red,
   output logic [15:0]       rsp_rgb_first,
   output logic [15:0]       rsp_rgb_second,
   output logic              rsp_line_end,
   output logic              rsp_frame_end
);

   localparam int XW   = $clog2(MAX_WIDTH);
   localparam int YW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int HW   = $clog2(MAX_HEIGHT + 1);
   localparam int MW   = (WW > HW) ? WW : HW;
   localparam int CLW  = ((MW > CSR_W) ? MW : CSR_W) + 1;
   localparam int VW   = ((XW + 1) > YW) ? (XW + 1) : YW;
   localparam int DVW  = VW + 8;
   localparam int TW   = (DVW > (CLW + 8)) ? DVW : (CLW + 8);
   localparam int BLW  = $clog2(BOUNCE_WIDTH + 2);
   localparam int BTW  = $clog2(BOUNCE_HEIGHT + 2);
   localparam int BMW  = (BLW > BTW) ? BLW : BTW;
   localparam int CMW  = ((VW > BMW) ? VW : BMW) + 9;
   localparam int BOUND_X = BOUNCE_WIDTH - BOX_SIZE;
   localparam int BOUND_Y = BOUNCE_HEIGHT - BOX_SIZE;

   logic [CLW-1:0] w_c, h_c, fw_x, fh_x, col_adv, row_adv;
   logic [XW-1:0]  column_ff, x_now, x_ff;
   logic [YW-1:0]  row_ff, y_now, y_ff;
   logic           second_ff, le_ff, fe_ff;
   logic [BLW-1:0] box_left_ff, left_next;
   logic [BTW-1:0] box_top_ff, top_next;
   logic           box_moving_left_ff, box_moving_up_ff;

   logic [VW-1:0]  v_sel;
   logic [DVW-1:0] dividend;
   logic [CLW-1:0] divisor;
   logic           ramp;
   logic [TW-1:0]  rem_ff, dsr_ff;
   logic [7:0]     q_ff, q_next;
   logic           ge;
   logic [7:0]     quot_ff [3];

   logic [15:0]    pix0, pix1, p0_ff, p1_ff, psel;
   logic [2:0]     idx0, idx1;
   logic [CMW-1:0] cx0, cx1, cy, cl, ct;
   logic           in0, in1;
   logic [7:0]     r8, g8, b8;
   logic signed [19:0] rs, gs, bs, sum_in, sum_ff;
   logic [18:0]    mag;
   logic [37:0]    prod_ff;
   logic           neg_ff;
   logic [8:0]     q9;
   logic signed [10:0] fv;
   logic [7:0]     fclamp;
   logic [7:0]     yuv_ff [4];
   logic           rsp_valid_ff;

   // Frame size, clamped to the supported range.
   always_comb begin
      fw_x = CLW'(frame_width);
      fh_x = CLW'(frame_height);
      if (fw_x < CLW'(MIN_WIDTH)) begin
         w_c = CLW'(MIN_WIDTH);
      end else if (fw_x > CLW'(MAX_WIDTH)) begin
         w_c = CLW'(MAX_WIDTH);
      end else begin
         w_c = fw_x;
      end
      if (fh_x < CLW'(1)) begin
         h_c = CLW'(1);
      end else if (fh_x > CLW'(MAX_HEIGHT)) begin
         h_c = CLW'(MAX_HEIGHT);
      end else begin
         h_c = fh_x;
      end
      x_now   = (CLW'(column_ff) >= w_c) ? '0 : column_ff;
      y_now   = (CLW'(row_ff) >= h_c) ? '0 : row_ff;
      col_adv = CLW'(x_now) + CLW'(2);
      row_adv = CLW'(y_now) + CLW'(1);
   end

   always_comb begin
      left_next = box_moving_left_ff ? box_left_ff - BLW'(2) : box_left_ff + BLW'(2);
      top_next  = box_moving_up_ff ? box_top_ff - BTW'(2) : box_top_ff + BTW'(2);
   end

   // Raster position and box movement.
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff          <= '0;
         row_ff             <= '0;
         box_left_ff        <= '0;
         box_top_ff         <= '0;
         box_moving_left_ff <= 1'b0;
         box_moving_up_ff   <= 1'b0;
      end else begin
         if (cmd.accept_pair) begin
            if (col_adv >= w_c) begin
               column_ff <= '0;
               row_ff    <= (row_adv >= h_c) ? '0 : YW'(row_adv);
            end else begin
               column_ff <= XW'(col_adv);
               row_ff    <= y_now;
            end
         end
         if (cmd.accept_tick && tick_even) begin
            box_left_ff <= left_next;
            box_top_ff  <= top_next;
            if (left_next == '0 || int'(left_next) >= BOUND_X) begin
               box_moving_left_ff <= !box_moving_left_ff;
            end
            if (top_next == '0 || int'(top_next) >= BOUND_Y) begin
               box_moving_up_ff <= !box_moving_up_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept_pair) begin
         x_ff      <= x_now;
         y_ff      <= y_now;
         second_ff <= (CLW'(x_now) + CLW'(1)) < w_c;
         le_ff     <= col_adv >= w_c;
         fe_ff     <= (col_adv >= w_c) && (row_adv >= h_c);
      end
   end

   // Divider operands: first pixel column, second pixel column, row.
   always_comb begin
      case (cmd.slot)
         SLOT_X0: v_sel = VW'(x_ff);
         SLOT_X1: v_sel = VW'(x_ff) + VW'(1);
         default: v_sel = VW'(y_ff);
      endcase
      ramp     = (pattern_mode == MODE_RAMP_H) || (pattern_mode == MODE_RAMP_V);
      dividend = ramp ? ((DVW'(v_sel) << 8) - DVW'(v_sel)) : DVW'(v_sel);
      unique case (pattern_mode)
         MODE_BARS:    divisor = (cmd.slot == SLOT_ROW) ? CLW'(CHECK_SIZE) : (w_c >> 3);
         MODE_RAMP_H:  divisor = w_c;
         MODE_RAMP_V:  divisor = h_c;
         MODE_CHECKER: divisor = CLW'(CHECK_SIZE);
         default:      divisor = CLW'(1);
      endcase
      ge     = rem_ff >= dsr_ff;
      q_next = {q_ff[6:0], ge};
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff <= TW'(dividend);
         dsr_ff <= TW'(divisor) << 7;
         q_ff   <= '0;
      end else if (cmd.div_step) begin
         if (ge) begin
            rem_ff <= rem_ff - dsr_ff;
         end
         dsr_ff <= dsr_ff >> 1;
         q_ff   <= q_next;
      end
      if (cmd.div_last) begin
         case (cmd.slot)
            SLOT_X0: quot_ff[0] <= q_next;
            SLOT_X1: quot_ff[1] <= q_next;
            default: quot_ff[2] <= q_next;
         endcase
      end
   end

   // Pixel colours from the quotients, or from the box position in box mode.
   always_comb begin
      idx0 = (quot_ff[0] > 8'd7) ? 3'd7 : quot_ff[0][2:0];
      idx1 = (quot_ff[1] > 8'd7) ? 3'd7 : quot_ff[1][2:0];
      cx0  = CMW'(x_ff);
      cx1  = CMW'(x_ff) + CMW'(1);
      cy   = CMW'(y_ff);
      cl   = CMW'(box_left_ff);
      ct   = CMW'(box_top_ff);
      in0  = (cx0 >= cl) && (cx0 < cl + CMW'(BOX_SIZE)) &&
             (cy >= ct) && (cy < ct + CMW'(BOX_SIZE));
      in1  = (cx1 >= cl) && (cx1 < cl + CMW'(BOX_SIZE)) &&
             (cy >= ct) && (cy < ct + CMW'(BOX_SIZE));
      unique case (pattern_mode)
         MODE_BARS: begin
            pix0 = bar_colour(idx0);
            pix1 = bar_colour(idx1);
         end
         MODE_RAMP_H: begin
            pix0 = grey565(quot_ff[0]);
            pix1 = grey565(quot_ff[1]);
         end
         MODE_RAMP_V: begin
            pix0 = grey565(quot_ff[2]);
            pix1 = grey565(quot_ff[2]);
         end
         MODE_CHECKER: begin
            pix0 = (quot_ff[0][0] ^ quot_ff[2][0]) ? COLOUR_BLACK : COLOUR_WHITE;
            pix1 = (quot_ff[1][0] ^ quot_ff[2][0]) ? COLOUR_BLACK : COLOUR_WHITE;
         end
         MODE_GREEN: begin
            pix0 = COLOUR_GREEN;
            pix1 = COLOUR_GREEN;
         end
         MODE_BOX: begin
            pix0 = in0 ? COLOUR_RED : COLOUR_FIELD;
            pix1 = in1 ? COLOUR_RED : COLOUR_FIELD;
         end
         default: begin
            pix0 = COLOUR_BLACK;
            pix1 = COLOUR_BLACK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.pix) begin
         p0_ff <= pix0;
         p1_ff <= second_ff ? pix1 : pix0;
      end
   end

   // Colour conversion, one channel at a time: weighted sum, reciprocal
   // multiply for the division by 1000, then offset for chroma and clamp.
   always_comb begin
      psel = (cmd.ch == CH_LUMA1) ? p1_ff : p0_ff;
      r8   = {psel[15:11], psel[15:13]};
      g8   = {psel[10:5], psel[10:9]};
      b8   = {psel[4:0], psel[4:2]};
      rs   = signed'(20'(r8));
      gs   = signed'(20'(g8));
      bs   = signed'(20'(b8));
      case (cmd.ch)
         CH_U:    sum_in = 20'sd0 - 20'sd169 * rs - 20'sd331 * gs + 20'sd500 * bs;
         CH_V:    sum_in = 20'sd500 * rs - 20'sd419 * gs - 20'sd81 * bs;
         default: sum_in = 20'sd299 * rs + 20'sd587 * gs + 20'sd114 * bs;
      endcase
      mag = sum_ff[19] ? 19'(-sum_ff) : 19'(sum_ff);
      q9  = prod_ff[RECIP_SHIFT +: 9];
      fv  = neg_ff ? -signed'({2'b00, q9}) : signed'({2'b00, q9});
      if (cmd.ch == CH_U || cmd.ch == CH_V) begin
         fv = fv + 11'sd128;
      end
      if (fv < 11'sd0) begin
         fclamp = 8'd0;
      end else if (fv > 11'sd255) begin
         fclamp = 8'd255;
      end else begin
         fclamp = fv[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         sum_ff <= sum_in;
      end
      if (cmd.mul) begin
         prod_ff <= 38'(mag) * 38'(RECIP_1000);
         neg_ff  <= sum_ff[19];
      end
      if (cmd.fin) begin
         yuv_ff[cmd.ch] <= fclamp;
      end
   end

   // Output register.
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_luma_first  <= yuv_ff[CH_LUMA0];
         rsp_luma_second <= yuv_ff[CH_LUMA1];
         rsp_chroma_blue <= yuv_ff[CH_U];
         rsp_chroma_red  <= yuv_ff[CH_V];
         rsp_rgb_first   <= p0_ff;
         rsp_rgb_second  <= p1_ff;
         rsp_line_end    <= le_ff;
         rsp_frame_end   <= fe_ff;
      end
   end

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid)
      else $error("loaded request result not presented");

   a_box_even: assert property (@(posedge clock) disable iff (reset)
      !box_left_ff[0] && !box_top_ff[0])
      else $error("box position left the even grid");

endmodule

// ===== rtl/core/video_test_pattern_yuy2.sv =====
// An accepted pixel-pair request runs three 8-step divisions and a four-channel colour
// pass; new requests stall until its result is loaded into a free output register.
// A frame tick with an even frame number moves the box; ticks do not stall requests.
// The output register lets a new request in while a result waits to be taken.
// Synchronous reset sets mode 0, 320x240, raster position and box to zero.
module video_test_pattern_yuy2
   import vtp_pkg::*;
#(
   parameter int MAX_WIDTH     = 1024,
   parameter int MAX_HEIGHT    = 1024,
   parameter int BOX_SIZE      = 40,
   parameter int BOUNCE_WIDTH  = 320,
   parameter int BOUNCE_HEIGHT = 240
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_func,
   input  logic [31:0]       req_frame_number,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_luma_first,
   output logic [7:0]        rsp_chroma_blue,
   output logic [7:0]        rsp_luma_second,
   output logic [7:0]        rsp_chroma_red,
   output logic [15:0]       rsp_rgb_first,
   output logic [15:0]       rsp_rgb_second,
   output logic              rsp_line_end,
   output logic              rsp_frame_end,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [CSR_W-1:0]  csr_write_data
);

   logic [2:0]       pattern_mode_ff;
   logic [CSR_W-1:0] frame_width_ff;
   logic [CSR_W-1:0] frame_height_ff;
   vtp_cmd_type      cmd;
   vtp_sts_type      sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_mode_ff <= MODE_BARS;
         frame_width_ff  <= CSR_W'(320);
         frame_height_ff <= CSR_W'(240);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PATTERN_MODE: pattern_mode_ff <= csr_write_data[2:0];
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_write_data;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   vtp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .sts       (sts),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   vtp_dp #(
      .MAX_WIDTH     (MAX_WIDTH),
      .MAX_HEIGHT    (MAX_HEIGHT),
      .BOX_SIZE      (BOX_SIZE),
      .BOUNCE_WIDTH  (BOUNCE_WIDTH),
      .BOUNCE_HEIGHT (BOUNCE_HEIGHT)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .pattern_mode    (pattern_mode_ff),
      .frame_width     (frame_width_ff),
      .frame_height    (frame_height_ff),
      .tick_even       (!req_frame_number[0]),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_luma_first  (rsp_luma_first),
      .rsp_chroma_blue (rsp_chroma_blue),
      .rsp_luma_second (rsp_luma_second),
      .rsp_chroma_red  (rsp_chroma_red),
      .rsp_rgb_first   (rsp_rgb_first),
      .rsp_rgb_second  (rsp_rgb_second),
      .rsp_line_end    (rsp_line_end),
      .rsp_frame_end   (rsp_frame_end)
   );

endmodule

// ===== test/video_test_pattern_yuy2_tb.sv =====
`timescale 1ns / 100ps

module video_test_pattern_yuy2_tb;
   import vtp_pkg::*;

   localparam int MAX_W = 1024;
   localparam int MAX_H = 1024;
   localparam int BOX = 40;
   localparam int BOUNCE_W = 320;
   localparam int BOUNCE_H = 240;
   localparam logic FUNC_PAIR = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   typedef struct packed {
      logic        func;
      logic [31:0] frame_number;
   } request_t;

   typedef struct packed {
      logic [7:0]  luma_first;
      logic [7:0]  chroma_blue;
      logic [7:0]  luma_second;
      logic [7:0]  chroma_red;
      logic [15:0] rgb_first;
      logic [15:0] rgb_second;
      logic        line_end;
      logic        frame_end;
   } pair_t;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_func;
   logic [31:0] req_frame_number;
   logic rsp_valid;
   logic rsp_stall;
   logic [7:0] rsp_luma_first, rsp_chroma_blue, rsp_luma_second, rsp_chroma_red;
   logic [15:0] rsp_rgb_first, rsp_rgb_second;
   logic rsp_line_end, rsp_frame_end;
   logic csr_write_enable;
   logic [1:0] csr_index;
   logic [CSR_W-1:0] csr_write_data;

   request_t pending_requests[$];
   pair_t expected_pairs[$];
   int mismatches = 0;
   int stim_done = 0;
   int req_gap = 0;
   int rsp_gap = 0;

   logic [2:0] mode_shadow;
   logic [10:0] width_shadow, height_shadow;
   int column_pos, row_pos, box_x, box_y;
   bit box_back_x, box_back_y;

   video_test_pattern_yuy2 u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_func(req_func), .req_frame_number(req_frame_number),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_luma_first(rsp_luma_first), .rsp_chroma_blue(rsp_chroma_blue),
      .rsp_luma_second(rsp_luma_second), .rsp_chroma_red(rsp_chroma_red),
      .rsp_rgb_first(rsp_rgb_first), .rsp_rgb_second(rsp_rgb_second),
      .rsp_line_end(rsp_line_end), .rsp_frame_end(rsp_frame_end),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] grey_pixel(input int i);
      logic [7:0] v;
      v = i[7:0];
      return {v[7:3], v[7:2], v[7:3]};
   endfunction

   function automatic logic [15:0] pattern_pixel(input int x, input int y, input int w,
                                                 input int h);
      int idx;
      case (mode_shadow)
         MODE_BARS: begin
            idx = x / (w / 8);
            if (idx > 7) idx = 7;
            case (idx)
               0: return 16'hFFFF;
               1: return 16'hFFE0;
               2: return 16'h07FF;
               3: return 16'h07E0;
               4: return 16'hF81F;
               5: return 16'hF800;
               6: return 16'h001F;
               default: return 16'h0000;
            endcase
         end
         MODE_RAMP_H: return grey_pixel((x * 255) / w);
         MODE_RAMP_V: return grey_pixel((y * 255) / h);
         MODE_CHECKER: return (((x / 20) + (y / 20)) % 2 == 0) ? 16'hFFFF : 16'h0000;
         MODE_GREEN: return 16'h07E0;
         MODE_BOX: begin
            if (x >= box_x && x < box_x + BOX && y >= box_y && y < box_y + BOX)
               return 16'hF800;
            return 16'h0010;
         end
         default: return 16'h0000;
      endcase
   endfunction

   function automatic int clip_byte(input int v);
      if (v < 0) return 0;
      if (v > 255) return 255;
      return v;
   endfunction

   function automatic void split_rgb(input logic [15:0] p, output int r, output int g,
                                     output int b);
      r = {p[15:11], p[15:13]};
      g = {p[10:5], p[10:9]};
      b = {p[4:0], p[4:2]};
   endfunction

   function automatic int luma_of(input logic [15:0] p);
      int r, g, b;
      split_rgb(p, r, g, b);
      return clip_byte((299 * r + 587 * g + 114 * b) / 1000);
   endfunction

   function automatic void step_box(inout int pos, inout bit back, input int bound);
      pos = back ? pos - 2 : pos + 2;
      if (pos <= 0 || pos >= bound) back = !back;
   endfunction

   function automatic void predict_pair(input request_t rq);
      int w, h, r, g, b;
      pair_t e;
      logic [15:0] p0, p1;
      if (rq.func == FUNC_TICK) begin
         if (!rq.frame_number[0]) begin
            step_box(box_x, box_back_x, BOUNCE_W - BOX);
            step_box(box_y, box_back_y, BOUNCE_H - BOX);
         end
         return;
      end
      w = width_shadow;
      if (w < 8) w = 8;
      if (w > MAX_W) w = MAX_W;
      h = height_shadow;
      if (h < 1) h = 1;
      if (h > MAX_H) h = MAX_H;
      if (column_pos >= w) column_pos = 0;
      if (row_pos >= h) row_pos = 0;
      p0 = pattern_pixel(column_pos, row_pos, w, h);
      p1 = (column_pos + 1 < w) ? pattern_pixel(column_pos + 1, row_pos, w, h) : p0;
      split_rgb(p0, r, g, b);
      e.luma_first = luma_of(p0);
      e.chroma_blue = clip_byte((-169 * r - 331 * g + 500 * b) / 1000 + 128);
      e.luma_second = luma_of(p1);
      e.chroma_red = clip_byte((500 * r - 419 * g - 81 * b) / 1000 + 128);
      e.rgb_first = p0;
      e.rgb_second = p1;
      e.line_end = 1'b0;
      e.frame_end = 1'b0;
      column_pos += 2;
      if (column_pos >= w) begin
         column_pos = 0;
         e.line_end = 1'b1;
         row_pos++;
         if (row_pos >= h) begin
            row_pos = 0;
            e.frame_end = 1'b1;
         end
      end
      expected_pairs.push_back(e);
   endfunction

   always @(posedge clock) begin
      request_t nxt;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else if (req_valid && !req_stall) begin
         predict_pair('{func: req_func, frame_number: req_frame_number});
         if (pending_requests.size() > 0 && $urandom_range(0, 3) == 0) begin
            nxt = pending_requests.pop_front();
            req_func <= nxt.func;
            req_frame_number <= nxt.frame_number;
         end else begin
            req_valid <= 1'b0;
            req_gap <= $urandom_range(0, 16);
         end
      end else if (!req_valid && pending_requests.size() > 0) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
         end else begin
            nxt = pending_requests.pop_front();
            req_valid <= 1'b1;
            req_func <= nxt.func;
            req_frame_number <= nxt.frame_number;
         end
      end
   end

   always @(posedge clock) begin
      pair_t got, want;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_gap <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_luma_first, rsp_chroma_blue, rsp_luma_second, rsp_chroma_red,
                    rsp_rgb_first, rsp_rgb_second, rsp_line_end, rsp_frame_end};
            if (expected_pairs.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected pair %h", got);
            end else begin
               want = expected_pairs.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("pair mismatch: expected %h, got %h", want, got);
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_stall <= 1'b1;
            rsp_gap <= rsp_gap - 1;
         end else begin
            rsp_stall <= 1'b0;
            rsp_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
         end
      end
   end

   task automatic write_csr(input logic [1:0] idx, input int value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value[CSR_W-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_PATTERN_MODE) mode_shadow = value[2:0];
      else if (idx == CSR_FRAME_WIDTH) width_shadow = value[10:0];
      else height_shadow = value[10:0];
   endtask

   task automatic queue_request(input logic func, input logic [31:0] frame);
      pending_requests.push_back('{func: func, frame_number: frame});
   endtask

   task automatic drain;
      wait (pending_requests.size() == 0 && !req_valid);
      while (expected_pairs.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   initial begin
      int widths[$] = '{0, 7, 8, 9, 17, 2047, 1024, 13, 320, 41, 1023};
      int heights[$] = '{0, 1, 2047, 1024, 3, 2, 5, 240, 7, 4, 1};
      int n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_PAIR;
      req_frame_number = '0;
      rsp_stall = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_PATTERN_MODE;
      csr_write_data = '0;
      mode_shadow = MODE_BARS;
      width_shadow = 11'd320;
      height_shadow = 11'd240;
      column_pos = 0;
      row_pos = 0;
      box_x = 0;
      box_y = 0;
      box_back_x = 0;
      box_back_y = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: default bars, ticks with odd and extreme frame numbers, every mode.
      for (int i = 0; i < 6; i++) queue_request(FUNC_PAIR, 32'hFFFF_FFFF);
      queue_request(FUNC_TICK, 32'hFFFF_FFFF);
      queue_request(FUNC_TICK, 32'h0);
      queue_request(FUNC_TICK, 32'hFFFF_FFFE);
      drain();
      for (int m = 0; m < 8; m++) begin
         write_csr(CSR_PATTERN_MODE, m);
         write_csr(CSR_FRAME_WIDTH, 9);
         write_csr(CSR_FRAME_HEIGHT, 2);
         for (int i = 0; i < 2; i++) queue_request(FUNC_PAIR, $urandom);
         drain();
      end

      for (int phase = 0; phase < widths.size(); phase++) begin
         write_csr(CSR_PATTERN_MODE, $urandom_range(0, 7));
         write_csr(CSR_FRAME_WIDTH, widths[phase]);
         write_csr(CSR_FRAME_HEIGHT, heights[phase]);
         n = 0;
         while (n < 110) begin
            if ($urandom_range(0, 9) == 0) begin
               queue_request(FUNC_TICK, $urandom);
            end else begin
               queue_request(FUNC_PAIR, $urandom);
               n++;
            end
         end
         // Many even ticks let the box bounce off every wall.
         if (phase == 3)
            for (int i = 0; i < 300; i++) queue_request(FUNC_TICK, {$urandom} << 1);
         drain();
      end
      stim_done = 1;
   end

   initial begin
      wait (stim_done == 1);
      if (mismatches == 0 && expected_pairs.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule
